// ===== src/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg: shared types and constants for the ASK frame chip encoder
// Holds the descriptor that passes from the front to the back, the chip
// record, the register indexes and the protocol codes.
// ----------------------------------------------------------------------------
package afc_pkg;

  // Width in which the bit times are held, clipped to the register width.
  localparam int TimeWidth    = 16;
  localparam int CfgDataWidth = 16;
  localparam int TimeBits     = (TimeWidth < CfgDataWidth) ? TimeWidth : CfgDataWidth;
  localparam int CfgIdxWidth  = 3;
  localparam int DurWidth     = 19;
  localparam int QueueDepth   = 2;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxWidth-1:0] RegLeadProto = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegDataProto = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegLeadTime  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegDataTime  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegEndHigh   = 3'd4;

  // Chip protocol codes. The spare code behaves as the plain protocol.
  localparam logic [1:0] ProtoPlain = 2'd0;
  localparam logic [1:0] ProtoThree = 2'd1;
  localparam logic [1:0] ProtoPulse = 2'd2;
  localparam logic [1:0] ProtoSpare = 2'd3;

  // Bit count of a full byte.
  localparam logic [3:0] FullCount = 4'd8;

  // One classified frame byte, ready for chip generation.
  typedef struct packed {
    logic [7:0]          data_byte;
    logic [3:0]          bit_count;
    logic [1:0]          proto;
    logic [TimeBits-1:0] bit_time;
    logic                end_of_frame;
    logic [TimeBits-1:0] end_high;
    logic [DurWidth-1:0] end_low;
  } desc_t;

  // One chip on the transmit line.
  typedef struct packed {
    logic                level;
    logic [DurWidth-1:0] duration;
    logic                last;
  } chip_t;

endpackage

// ===== src/ask_frame_chip_encoder_core.sv =====
// ----------------------------------------------------------------------------
// ask_frame_chip_encoder_core: OOK pulse-width chip encoder, top level
// Turns tagged frame bytes into chips of line level and duration.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+------------------------------------------
//   bytes in | push / full        | data_byte, bit_count, group_select, eof
//   chips out| pop / empty        | line_level, chip_duration, last_chip
//   config   | cfg_we_i           | cfg_index_i, cfg_wdata_i
//
// The chip sequencer sends one chip per cycle while the output register is
// free or being popped. A full byte in the three-chip protocol has 24 chips,
// plus two for a frame end. The front takes one byte per cycle while its
// two-entry descriptor queue has room. Reset restores the default
// configuration and empties the queue and the output register. With pop low
// the output chip holds and the sequencer waits; the queue keeps filling.
// ----------------------------------------------------------------------------
module ask_frame_chip_encoder_core import afc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [7:0]              data_byte_i,
  input  logic [3:0]              bit_count_i,
  input  logic                    group_select_i,
  input  logic                    end_of_frame_i,
  output logic                    empty,
  input  logic                    pop,
  output logic                    line_level_o,
  output logic [DurWidth-1:0]     chip_duration_o,
  output logic                    last_chip_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i
);

  logic  q_wr, q_full, q_rd, q_valid, out_valid;
  desc_t q_wdata, q_rdata;
  chip_t chip;

  afc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .data_byte_i    (data_byte_i),
    .bit_count_i    (bit_count_i),
    .group_select_i (group_select_i),
    .end_of_frame_i (end_of_frame_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .q_full_i       (q_full),
    .q_wr_o         (q_wr),
    .q_wdata_o      (q_wdata)
  );

  afc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  afc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_rdata_i   (q_rdata),
    .q_rd_o      (q_rd),
    .pop         (pop),
    .out_valid_o (out_valid),
    .chip_o      (chip)
  );

  // The input side sees the queue's full flag; empty comes from the output register.
  assign full            = q_full;
  assign empty           = !out_valid;
  assign line_level_o    = chip.level;
  assign chip_duration_o = chip.duration;
  assign last_chip_o     = chip.last;

endmodule

// ===== src/afc_front.sv =====
// ----------------------------------------------------------------------------
// afc_front: configuration registers and byte classification
// Holds the configuration, saturates the bit count, selects the protocol and
// the chip times of the byte's group, and writes one descriptor per request
// that causes at least one chip.
// ----------------------------------------------------------------------------
module afc_front import afc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  input  logic [7:0]              data_byte_i,
  input  logic [3:0]              bit_count_i,
  input  logic                    group_select_i,
  input  logic                    end_of_frame_i,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  input  logic                    q_full_i,
  output logic                    q_wr_o,
  output desc_t                   q_wdata_o
);

  logic [1:0]              lead_proto_q;
  logic [1:0]              data_proto_q;
  logic [CfgDataWidth-1:0] lead_time_q;
  logic [CfgDataWidth-1:0] data_time_q;
  logic [CfgDataWidth-1:0] end_high_q;

  logic [3:0]          count;
  logic [1:0]          raw_proto;
  logic [TimeBits-1:0] data_time;
  logic [DurWidth-1:0] data_time_ext;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_proto_q <= ProtoPlain;
      data_proto_q <= ProtoPlain;
      lead_time_q  <= CfgDataWidth'(1);
      data_time_q  <= CfgDataWidth'(1);
      end_high_q   <= CfgDataWidth'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegLeadProto: lead_proto_q <= cfg_wdata_i[1:0];
        RegDataProto: data_proto_q <= cfg_wdata_i[1:0];
        RegLeadTime:  lead_time_q  <= cfg_wdata_i;
        RegDataTime:  data_time_q  <= cfg_wdata_i;
        RegEndHigh:   end_high_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Classification of the incoming byte.
  always_comb begin
    count         = (bit_count_i > FullCount) ? FullCount : bit_count_i;
    raw_proto     = group_select_i ? data_proto_q : lead_proto_q;
    data_time     = data_time_q[TimeBits-1:0];
    data_time_ext = DurWidth'(data_time);

    q_wdata_o.data_byte    = data_byte_i;
    q_wdata_o.bit_count    = count;
    // Partial bytes and the unused code fall back to the plain protocol.
    q_wdata_o.proto        = (count != FullCount || raw_proto == ProtoSpare)
                             ? ProtoPlain : raw_proto;
    q_wdata_o.bit_time     = group_select_i ? data_time : lead_time_q[TimeBits-1:0];
    q_wdata_o.end_of_frame = end_of_frame_i;
    q_wdata_o.end_high     = end_high_q[TimeBits-1:0];
    // The trailing low lasts six data bit times.
    q_wdata_o.end_low      = (data_time_ext << 2) + (data_time_ext << 1);

    // A byte with no bits and no frame end causes no chips and is dropped.
    q_wr_o = push && !q_full_i && (count != 4'd0 || end_of_frame_i);
  end

endmodule

// ===== src/afc_queue.sv =====
// ----------------------------------------------------------------------------
// afc_queue: descriptor queue between front and back
// A small register FIFO that lets the front keep taking bytes while the back
// is still sending chips of earlier ones.
// ----------------------------------------------------------------------------
module afc_queue import afc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  input  desc_t wdata_i,
  output logic  full_o,
  input  logic  rd_i,
  output logic  valid_o,
  output desc_t rdata_o
);

  localparam int PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntWidth = $clog2(QueueDepth + 1);

  desc_t               mem_q [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntWidth'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== src/afc_back.sv =====
// ----------------------------------------------------------------------------
// afc_back: chip sequencer
// Walks the bits of one descriptor, most significant first, and the chips of
// each bit, then the frame-end chips, writing one chip per cycle into the
// output register while it is free or being emptied.
// ----------------------------------------------------------------------------
module afc_back import afc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  input  desc_t q_rdata_i,
  output logic  q_rd_o,
  input  logic  pop,
  output logic  out_valid_o,
  output chip_t chip_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BITS,
    ST_END_HI,
    ST_END_LO
  } state_e;

  state_e     state_q;
  desc_t      desc_q;
  logic [3:0] remain_q;
  logic [1:0] phase_q;
  logic       out_valid_q;
  chip_t      chip_q;

  logic [2:0] bit_idx;
  logic       cur_bit;
  logic [1:0] last_phase;
  logic       last_of_bit;
  logic       emit;
  logic       finish;
  chip_t      chip_d;

  assign out_valid_o = out_valid_q;
  assign chip_o      = chip_q;

  // Chip of the current position.
  always_comb begin
    bit_idx = 3'(remain_q - 4'd1);
    cur_bit = desc_q.data_byte[bit_idx];
    case (desc_q.proto)
      ProtoThree: last_phase = 2'd2;
      ProtoPulse: last_phase = cur_bit ? 2'd2 : 2'd1;
      default:    last_phase = 2'd0;
    endcase
    last_of_bit = (phase_q == last_phase);

    chip_d.duration = DurWidth'(desc_q.bit_time);
    case (phase_q)
      2'd0:    chip_d.level = (desc_q.proto == ProtoPlain) ? cur_bit : 1'b1;
      2'd1:    chip_d.level = (desc_q.proto == ProtoThree) ? cur_bit : 1'b0;
      default: chip_d.level = 1'b0;
    endcase
    chip_d.last = last_of_bit && remain_q == 4'd1 && !desc_q.end_of_frame;

    case (state_q)
      ST_END_HI: begin
        chip_d.level    = 1'b1;
        chip_d.duration = DurWidth'(desc_q.end_high);
        chip_d.last     = 1'b0;
      end
      ST_END_LO: begin
        chip_d.level    = 1'b0;
        chip_d.duration = desc_q.end_low;
        chip_d.last     = 1'b1;
      end
      default: ;
    endcase

    // A chip moves on when the output register is free or being emptied.
    emit   = (state_q != ST_IDLE) && (!out_valid_q || pop);
    finish = emit && chip_d.last;
    q_rd_o = q_valid_i && (state_q == ST_IDLE || finish);
  end

  // Sequencer state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      remain_q    <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        chip_q      <= chip_d;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end

      if (q_rd_o) begin
        desc_q   <= q_rdata_i;
        remain_q <= q_rdata_i.bit_count;
        phase_q  <= '0;
        state_q  <= (q_rdata_i.bit_count != 4'd0) ? ST_BITS : ST_END_HI;
      end else if (finish) begin
        state_q <= ST_IDLE;
      end else if (emit) begin
        case (state_q)
          ST_BITS: begin
            if (!last_of_bit) begin
              phase_q <= phase_q + 2'd1;
            end else if (remain_q != 4'd1) begin
              remain_q <= remain_q - 4'd1;
              phase_q  <= '0;
            end else begin
              state_q <= ST_END_HI;
            end
          end
          ST_END_HI: state_q <= ST_END_LO;
          default:   state_q <= ST_IDLE;
        endcase
      end
    end
  end

endmodule

// ===== src/afc_checker.sv =====
// ----------------------------------------------------------------------------
// afc_checker: port-level checks for the chip encoder
// Watches the top level's ports and flags broken chip delivery.
// ----------------------------------------------------------------------------
module afc_checker import afc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                empty,
  input logic                pop,
  input logic                line_level_o,
  input logic [DurWidth-1:0] chip_duration_o,
  input logic                last_chip_o
);

  // Nothing is offered while reset is applied.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("chip offered during reset");

  // A waiting chip holds until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(line_level_o) &&
                          $stable(chip_duration_o) && $stable(last_chip_o)))
    else $error("waiting chip changed");

  // Chips of one byte follow each other without a gap.
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_chip_o) |=> !empty)
    else $error("gap inside the chips of one byte");

  // No chip is longer than six full bit times.
  a_dur_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (chip_duration_o <= DurWidth'(393210)))
    else $error("chip duration out of range");

endmodule

bind ask_frame_chip_encoder_core afc_checker u_checker (.*);
